// ===== design/dtc_pkg.sv =====
package dtc_pkg;

   localparam int MAX_HEIGHT_DEF = 10;
   localparam int SIDE_W = 16;
   localparam int COUNT_W = 30;
   localparam logic [COUNT_W-1:0] TILE_MOD = 30'd1000000007;

   typedef struct packed {
      logic [SIDE_W-1:0] side_a;
      logic [SIDE_W-1:0] side_b;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] tiling_count;
      logic               too_tall;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_RUN,
      ST_DRAIN,
      ST_FETCH,
      ST_WAIT,
      ST_RESULT
   } state_type;

endpackage

// ===== design/domino_tiling_counter_top.sv =====
// for an h x L grid (h the smaller side) the count memories are swept one profile entry per cycle,
// h cell passes per column
// a grid taller than MAX_HEIGHT or with an empty side is answered without using the count memories
// one item at a time; the next item is taken while the previous result waits
// reset (synchronous, active high) clears control and output valid; the count memories
// are not cleared, each item rewrites them before use
module domino_tiling_counter_top
   import dtc_pkg::*;
#(
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int MW = MAX_HEIGHT;
   localparam int DEPTH = 1 << MW;
   localparam int CW = $clog2(MAX_HEIGHT + 1);

   state_type state_ff, state_in;

   logic              sel_ff, sel_in;       // 1: current column counts live in mem_b
   logic [MW-1:0]     n_ff, n_in;
   logic [MW-1:0]     lim_ff, lim_in;
   logic [CW-1:0]     cell_ff, cell_in;
   logic [CW-1:0]     height_ff, height_in;
   logic [SIDE_W-1:0] col_ff, col_in;
   logic [SIDE_W-1:0] len_ff, len_in;

   logic              v1_ff, v1_in;
   logic [MW-1:0]     n1_ff;
   logic              use1_ff, use1_in;

   logic [COUNT_W-1:0] res_count_ff, res_count_in;
   logic               res_tall_ff, res_tall_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [COUNT_W-1:0] mem_a [DEPTH];
   logic [COUNT_W-1:0] mem_b [DEPTH];
   logic [COUNT_W-1:0] rda0_ff, rda1_ff, rdb0_ff, rdb1_ff;

   logic [MW-1:0]      rd_addr0, rd_addr1, wr_addr;
   logic [COUNT_W-1:0] wr_data;
   logic               we_a, we_b;

   logic [SIDE_W-1:0]  req_h, req_len;
   logic               req_tall, req_zero, req_take;
   logic [CW-1:0]      shamt;

   logic [MW-1:0]      bit_i, bit_j, addr0, addr1;
   logic               n_bi, n_bj, vert_ok, use1_now;
   logic [CW:0]        cell_nx;
   logic               n_last, cell_last, col_last;

   logic [COUNT_W-1:0] src0, src1;
   logic [COUNT_W:0]   sum1;
   logic [COUNT_W-1:0] modsum;
   logic               out_free;

   // request decode
   always_comb begin
      req_h    = (req_data.side_a < req_data.side_b) ? req_data.side_a : req_data.side_b;
      req_len  = (req_data.side_a < req_data.side_b) ? req_data.side_b : req_data.side_a;
      req_tall = req_h > SIDE_W'(MAX_HEIGHT);
      req_zero = req_h == '0;
      req_take = req_valid && (state_ff == ST_IDLE);
      shamt    = CW'(MAX_HEIGHT) - req_h[CW-1:0];
   end

   // pull form of the broken-profile step: destination n at cell i gathers from n with bit i
   // toggled, plus n with bit i+1 cleared when bit i is clear, bit i+1 is set and i+1 < height
   always_comb begin
      bit_i    = MW'(1) << cell_ff;
      bit_j    = MW'(1) << (cell_ff + CW'(1));
      n_bi     = |(n_ff & bit_i);
      n_bj     = |(n_ff & bit_j);
      cell_nx  = {1'b0, cell_ff} + (CW+1)'(1);
      vert_ok  = cell_nx < {1'b0, height_ff};
      addr0    = n_bi ? (n_ff & ~bit_i) : (n_ff | bit_i);
      addr1    = n_ff & ~bit_j;
      use1_now = !n_bi && n_bj && vert_ok;
      n_last    = n_ff == lim_ff;
      cell_last = cell_nx == {1'b0, height_ff};
      col_last  = SIDE_W'(col_ff + SIDE_W'(1)) == len_ff;
   end

   // stage 1: combine the two source counts
   always_comb begin
      src0   = sel_ff ? rdb0_ff : rda0_ff;
      src1   = sel_ff ? rdb1_ff : rda1_ff;
      sum1   = {1'b0, src0} + {1'b0, (use1_ff ? src1 : '0)};
      modsum = (sum1 >= {1'b0, TILE_MOD}) ? COUNT_W'(sum1 - {1'b0, TILE_MOD})
                                           : sum1[COUNT_W-1:0];
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_tall || req_zero) ? ST_RESULT : ST_FILL;
            end
         end
         ST_FILL: begin
            if (n_last) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (n_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = (cell_last && col_last) ? ST_FETCH : ST_RUN;
         end
         ST_FETCH:  state_in = ST_WAIT;
         ST_WAIT:   state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      sel_in       = sel_ff;
      n_in         = n_ff;
      lim_in       = lim_ff;
      cell_in      = cell_ff;
      height_in    = height_ff;
      col_in       = col_ff;
      len_in       = len_ff;
      v1_in        = 1'b0;
      use1_in      = use1_now;
      res_count_in = res_count_ff;
      res_tall_in  = res_tall_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_addr0     = addr0;
      rd_addr1     = addr1;
      wr_addr      = n1_ff;
      wr_data      = modsum;
      we_a         = v1_ff && sel_ff;
      we_b         = v1_ff && !sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               res_tall_in  = req_tall;
               res_count_in = req_tall ? '0 : COUNT_W'(1);
               height_in    = req_h[CW-1:0];
               len_in       = req_len;
               lim_in       = {MW{1'b1}} >> shamt;
               n_in         = '0;
            end
         end
         ST_FILL: begin
            // seed the current column: only the all-clear profile counts one
            wr_addr = n_ff;
            wr_data = (n_ff == '0) ? COUNT_W'(1) : '0;
            we_a    = !sel_ff;
            we_b    = sel_ff;
            if (n_last) begin
               n_in    = '0;
               cell_in = '0;
               col_in  = '0;
            end else begin
               n_in = n_ff + MW'(1);
            end
         end
         ST_RUN: begin
            v1_in = 1'b1;
            n_in  = n_last ? '0 : n_ff + MW'(1);
         end
         ST_DRAIN: begin
            sel_in = !sel_ff;
            if (cell_last) begin
               cell_in = '0;
               col_in  = col_ff + SIDE_W'(1);
            end else begin
               cell_in = cell_nx[CW-1:0];
            end
         end
         ST_FETCH: begin
            rd_addr0 = '0;
         end
         ST_WAIT: begin
            res_count_in = src0;
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.tiling_count = res_count_ff;
               rsp_data_in.too_tall     = res_tall_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= 1'b0;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         cell_ff      <= '0;
         col_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         v1_ff        <= v1_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         cell_ff      <= cell_in;
         col_ff       <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff       <= lim_in;
      height_ff    <= height_in;
      len_ff       <= len_in;
      n1_ff        <= n_ff;
      use1_ff      <= use1_in;
      res_count_ff <= res_count_in;
      res_tall_ff  <= res_tall_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (we_a) mem_a[wr_addr] <= wr_data;
      rda0_ff <= mem_a[rd_addr0];
      rda1_ff <= mem_a[rd_addr1];
   end

   always_ff @(posedge clock) begin
      if (we_b) mem_b[wr_addr] <= wr_data;
      rdb0_ff <= mem_b[rd_addr0];
      rdb1_ff <= mem_b[rd_addr1];
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
